### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BGI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define BGI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`define BGI_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`else

`define BGI_ASSERT_IMP(lbl, ante, cons, msg)

`define BGI_ASSERT_NEXT(lbl, ante, cons, msg)

`define BGI_ASSERT_ALWAYS(lbl, expr, msg)

`endif

`endif

### hdl/bgi_pkg.sv
// ---------------------------------------------------------------------------
// bgi_pkg
// Shared widths, codes and item type of the bilinear grid interpolator.
// ---------------------------------------------------------------------------
package bgi_pkg;

	localparam int COORD_W  = 32;
	localparam int STEP_W   = 31;
	localparam int SAMPLE_W = 24;
	localparam int IDX_IN_W = 7;
	localparam int FRAC_W   = 16;
	localparam int QUO_W    = COORD_W + FRAC_W;   // integer part and fraction of d / step
	localparam int WGT_W    = 2 * FRAC_W + 1;     // product of two axis weights, up to 2^32
	localparam int TERM_W   = WGT_W + 1 + SAMPLE_W;

	localparam logic [FRAC_W:0] WEIGHT_ONE = 17'h1_0000;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_X_ORIGIN = 2'd0,
		CFG_X_STEP   = 2'd1,
		CFG_Y_ORIGIN = 2'd2,
		CFG_Y_STEP   = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic                valid;
		opcode_t             op;
		logic [IDX_IN_W-1:0] col;
		logic [IDX_IN_W-1:0] row;
		logic [SAMPLE_W-1:0] sample;
		logic                neg_x;
		logic                neg_y;
	} item_t;

endpackage

### hdl/bilinear_grid_interpolator.sv
// ---------------------------------------------------------------------------
// bilinear_grid_interpolator
// Grid sample store with pipelined bilinear point queries.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): tuser carries the opcode. A write transfer stores one
//   sample at (grid_col, grid_row) and gives no result; a query transfer
//   gives one result on the output stream (m_*): the interpolated value in
//   tdata and the out_of_range flag in tuser.
//   Configuration (cfg_*): origin and step per axis, written while idle;
//   cfg_ready is always high.
//   A query passes the input register, the 48-stage divider per axis, then
//   the locate, read, term, sum and output registers. Throughput: one item
//   per cycle unless the receiver stalls, writes and queries mixed freely.
//   The grid lives in four banks split by column and row parity, so the four
//   neighbors of a point are read in the same cycle. Writes pass down the same
//   pipeline and hit the banks at the read stage, which keeps store order.
//   Reset clears the pipeline and sets origins to 0 and steps to 256; the
//   grid content is undefined until written, with no clearing pass.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready drops; it is high whenever the output register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bilinear_grid_interpolator #(
	parameter int GRID_COLS = 128,
	parameter int GRID_ROWS = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // grid_col, grid_row, sample_value, query_x, query_y
	input  logic [0:0]   s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata,   // interpolated_value
	output logic [0:0]   m_tuser,   // out_of_range
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int CW    = bgi_pkg::COORD_W;
	localparam int SW    = bgi_pkg::STEP_W;
	localparam int DW    = bgi_pkg::SAMPLE_W;
	localparam int FW    = bgi_pkg::FRAC_W;
	localparam int QW    = bgi_pkg::QUO_W;
	localparam int WW    = bgi_pkg::WGT_W;
	localparam int TW    = bgi_pkg::TERM_W;
	localparam int IWX   = $clog2(GRID_COLS);
	localparam int IWY   = $clog2(GRID_ROWS);
	localparam int HC    = (GRID_COLS + 1) / 2;
	localparam int HR    = (GRID_ROWS + 1) / 2;
	localparam int DEPTH = HC * HR;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int AW1   = AW + 1;

	// ---------------- configuration ----------------
	logic signed [CW-1:0] x_origin_q, y_origin_q;
	logic [SW-1:0]        x_step_q, y_step_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= '0;
			y_origin_q <= '0;
			x_step_q   <= SW'(256);
			y_step_q   <= SW'(256);
		end else if (cfg_valid) begin
			unique case (bgi_pkg::cfg_index_t'(cfg_index))
				bgi_pkg::CFG_X_ORIGIN: x_origin_q <= cfg_data;
				bgi_pkg::CFG_X_STEP:
					x_step_q <= (cfg_data[SW-1:0] == '0) ? SW'(1) : cfg_data[SW-1:0];
				bgi_pkg::CFG_Y_ORIGIN: y_origin_q <= cfg_data;
				bgi_pkg::CFG_Y_STEP:
					y_step_q <= (cfg_data[SW-1:0] == '0) ? SW'(1) : cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- stall control ----------------
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ---------------- input stage ----------------
	logic signed [CW:0] dx, dy;
	bgi_pkg::item_t     in_item;
	bgi_pkg::item_t     p0_q;
	logic [CW-1:0]      p0_dx_q, p0_dy_q;

	assign dx = {s_tdata[69], s_tdata[69:38]} - {x_origin_q[CW-1], x_origin_q};
	assign dy = {s_tdata[101], s_tdata[101:70]} - {y_origin_q[CW-1], y_origin_q};

	always_comb begin
		in_item.valid  = s_tvalid;
		in_item.op     = bgi_pkg::opcode_t'(s_tuser[0]);
		in_item.col    = s_tdata[6:0];
		in_item.row    = s_tdata[13:7];
		in_item.sample = s_tdata[37:14];
		in_item.neg_x  = dx[CW];
		in_item.neg_y  = dy[CW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_q <= '0;
		end else if (adv) begin
			p0_q <= in_item;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_dx_q <= dx[CW-1:0];
			p0_dy_q <= dy[CW-1:0];
		end
	end

	// ---------------- dividers and sideband ----------------
	logic [QW-1:0]  quo_x, quo_y;
	bgi_pkg::item_t side_q [QW];

	bgi_div u_div_x (
		.clk      (clk),
		.en       (adv),
		.dividend (p0_dx_q),
		.divisor  (x_step_q),
		.quotient (quo_x)
	);

	bgi_div u_div_y (
		.clk      (clk),
		.en       (adv),
		.dividend (p0_dy_q),
		.divisor  (y_step_q),
		.quotient (quo_y)
	);

	for (genvar k = 0; k < QW; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_q[k] <= '0;
			end else if (adv) begin
				side_q[k] <= (k == 0) ? p0_q : side_q[(k == 0) ? 0 : k - 1];
			end
		end
	end

	// ---------------- locate: clamp index, split fraction ----------------
	bgi_pkg::item_t side_last;
	logic [CW-1:0]  q_x, q_y;
	logic [FW-1:0]  w_x, w_y;
	logic [IWX-1:0] fi_c;
	logic [IWY-1:0] fj_c;
	logic [FW-1:0]  wx_c, wy_c;
	logic           oor_x, oor_y;

	assign side_last = side_q[QW-1];
	assign q_x = quo_x[QW-1:FW];
	assign w_x = quo_x[FW-1:0];
	assign q_y = quo_y[QW-1:FW];
	assign w_y = quo_y[FW-1:0];

	always_comb begin
		if (side_last.neg_x) begin
			fi_c = '0;  wx_c = '0;  oor_x = 1'b1;
		end else if (q_x > CW'(GRID_COLS - 1) || (q_x == CW'(GRID_COLS - 1) && w_x != '0)) begin
			fi_c = IWX'(GRID_COLS - 1);  wx_c = '0;  oor_x = 1'b1;
		end else begin
			fi_c = q_x[IWX-1:0];  wx_c = w_x;  oor_x = 1'b0;
		end
		if (side_last.neg_y) begin
			fj_c = '0;  wy_c = '0;  oor_y = 1'b1;
		end else if (q_y > CW'(GRID_ROWS - 1) || (q_y == CW'(GRID_ROWS - 1) && w_y != '0)) begin
			fj_c = IWY'(GRID_ROWS - 1);  wy_c = '0;  oor_y = 1'b1;
		end else begin
			fj_c = q_y[IWY-1:0];  wy_c = w_y;  oor_y = 1'b0;
		end
	end

	bgi_pkg::item_t l_q;
	logic [IWX-1:0] l_fi_q;
	logic [IWY-1:0] l_fj_q;
	logic [FW-1:0]  l_wx_q, l_wy_q;
	logic           l_oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_q <= '0;
		end else if (adv) begin
			l_q <= side_last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_fi_q  <= fi_c;
			l_fj_q  <= fj_c;
			l_wx_q  <= wx_c;
			l_wy_q  <= wy_c;
			l_oor_q <= oor_x || oor_y;
		end
	end

	// ---------------- bank access: neighbor reads, sample writes ----------------
	logic          w_ok;
	logic [AW1-1:0] w_addr_full;
	logic [3:0]    bank_we;
	logic [DW-1:0] bank_rd [4];

	assign w_ok = l_q.valid && (l_q.op == bgi_pkg::OP_WRITE)
		&& (CW'(l_q.col) < CW'(GRID_COLS)) && (CW'(l_q.row) < CW'(GRID_ROWS));
	assign w_addr_full = AW1'(l_q.row[6:1]) * AW1'(HC) + AW1'(l_q.col[6:1]);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [IWX:0]   col_sel;
		logic [IWY:0]   row_sel;
		logic [AW1-1:0] r_addr_full;

		// pick fi or fi+1, whichever has this bank's parity; likewise for rows
		assign col_sel = (l_fi_q[0] == 1'(b % 2)) ? {1'b0, l_fi_q} : {1'b0, l_fi_q} + 1'b1;
		assign row_sel = (l_fj_q[0] == 1'(b / 2)) ? {1'b0, l_fj_q} : {1'b0, l_fj_q} + 1'b1;
		assign r_addr_full = AW1'(row_sel[IWY:1]) * AW1'(HC) + AW1'(col_sel[IWX:1]);
		assign bank_we[b] = adv && w_ok && ({l_q.row[0], l_q.col[0]} == 2'(b));

		bgi_bank #(
			.DEPTH (DEPTH),
			.AW    (AW)
		) u_bank (
			.clk   (clk),
			.en    (adv),
			.we    (bank_we[b]),
			.waddr (w_addr_full[AW-1:0]),
			.wdata (l_q.sample),
			.raddr (r_addr_full[AW-1:0]),
			.rdata (bank_rd[b])
		);
	end

	// weights for the four corners: (fi,fj), (fi+1,fj), (fi+1,fj+1), (fi,fj+1)
	logic [FW:0] wxa, wxb, wya, wyb;
	assign wxa = bgi_pkg::WEIGHT_ONE - {1'b0, l_wx_q};
	assign wxb = {1'b0, l_wx_q};
	assign wya = bgi_pkg::WEIGHT_ONE - {1'b0, l_wy_q};
	assign wyb = {1'b0, l_wy_q};

	logic          r_valid_s2, r_query_s2, r_oor_s2, r_pfi_s2, r_pfj_s2;
	logic [WW-1:0] r_w_s2 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_valid_s2 <= 1'b0;
		end else if (adv) begin
			r_valid_s2 <= l_q.valid && (l_q.op == bgi_pkg::OP_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_query_s2 <= l_q.op == bgi_pkg::OP_QUERY;
			r_oor_s2   <= l_oor_q;
			r_pfi_s2   <= l_fi_q[0];
			r_pfj_s2   <= l_fj_q[0];
			r_w_s2[0]  <= WW'(wxa) * WW'(wya);
			r_w_s2[1]  <= WW'(wxb) * WW'(wya);
			r_w_s2[2]  <= WW'(wxb) * WW'(wyb);
			r_w_s2[3]  <= WW'(wxa) * WW'(wyb);
		end
	end

	// ---------------- weighted terms ----------------
	logic [1:0]           corner_bank [4];
	logic signed [TW-1:0] m_t_s3 [4];
	logic                 m_valid_s3, m_oor_s3;

	assign corner_bank[0] = { r_pfj_s2,  r_pfi_s2};
	assign corner_bank[1] = { r_pfj_s2, ~r_pfi_s2};
	assign corner_bank[2] = {~r_pfj_s2, ~r_pfi_s2};
	assign corner_bank[3] = {~r_pfj_s2,  r_pfi_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_s3 <= 1'b0;
		end else if (adv) begin
			m_valid_s3 <= r_valid_s2 && r_query_s2;
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_term
		// a zero weight means the neighbor may lie past the grid: drop it outright
		always_ff @(posedge clk) begin
			if (adv) begin
				m_t_s3[c] <= (r_w_s2[c] == '0) ? '0
					: TW'($signed({1'b0, r_w_s2[c]})) * TW'($signed(bank_rd[corner_bank[c]]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_oor_s3 <= r_oor_s2;
		end
	end

	// ---------------- sum ----------------
	logic signed [TW:0] a_s01_s4, a_s23_s4;
	logic               a_valid_s4, a_oor_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_s4 <= 1'b0;
		end else if (adv) begin
			a_valid_s4 <= m_valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s01_s4 <= (TW+1)'(m_t_s3[0]) + (TW+1)'(m_t_s3[1]);
			a_s23_s4 <= (TW+1)'(m_t_s3[2]) + (TW+1)'(m_t_s3[3]);
			a_oor_s4 <= m_oor_s3;
		end
	end

	// ---------------- output register ----------------
	logic signed [TW+1:0] total;
	logic                 m_tvalid_q;
	logic [DW-1:0]        m_value_q;
	logic                 m_oor_q;

	// round half up, then drop the 32 weight fraction bits
	assign total = (TW+2)'(a_s01_s4) + (TW+2)'(a_s23_s4) + (TW+2)'(64'h8000_0000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= a_valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_value_q <= total[2*FW+DW-1:2*FW];
			m_oor_q   <= a_oor_s4;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_value_q;
	assign m_tuser[0] = m_oor_q;

	// ---------------- assertions ----------------
	`BGI_ASSERT_IMP(a_frac_below_last, l_q.valid && (l_wx_q != '0), l_fi_q != IWX'(GRID_COLS - 1), "x fraction at last column")
	`BGI_ASSERT_ALWAYS(a_one_bank_write, $onehot0(bank_we), "more than one bank written")
	`BGI_ASSERT_NEXT(a_result_follows, adv && a_valid_s4, m_tvalid, "query result lost at output")
	`BGI_ASSERT_IMP(a_write_no_result, adv && r_valid_s2 && !r_query_s2, 1'b0, "write item reached term stage as query")

endmodule

### hdl/bgi_div.sv
// ---------------------------------------------------------------------------
// bgi_div
// Pipelined restoring divider: one quotient bit per stage, 48 stages.
// ---------------------------------------------------------------------------
module bgi_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [bgi_pkg::COORD_W-1:0]  dividend,
	input  logic [bgi_pkg::STEP_W-1:0]   divisor,
	output logic [bgi_pkg::QUO_W-1:0]    quotient
);

	localparam int QW = bgi_pkg::QUO_W;
	localparam int SW = bgi_pkg::STEP_W;

	logic [SW-1:0] rem_q [QW-1];
	logic [QW-1:0] nq_q  [QW];

	// nq holds the dividend bits still to shift in on top, quotient bits below
	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [SW-1:0] rem_in;
		logic [QW-1:0] nq_in;
		logic [SW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = {dividend, {bgi_pkg::FRAC_W{1'b0}}};
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign nq_in  = nq_q[k-1];
		end

		assign trial = {rem_in, nq_in[QW-1]};
		assign ge    = trial >= {1'b0, divisor};

		always_ff @(posedge clk) begin
			if (en) begin
				nq_q[k] <= {nq_in[QW-2:0], ge};
			end
		end

		if (k < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= ge ? SW'(trial - {1'b0, divisor}) : trial[SW-1:0];
				end
			end
		end
	end

	assign quotient = nq_q[QW-1];

endmodule

### hdl/bgi_bank.sv
// ---------------------------------------------------------------------------
// bgi_bank
// One grid bank: synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bgi_bank #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [bgi_pkg::SAMPLE_W-1:0]  wdata,
	input  logic [AW-1:0]                 raddr,
	output logic [bgi_pkg::SAMPLE_W-1:0]  rdata
);

	logic [bgi_pkg::SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### verif/bilinear_grid_interpolator_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bilinear_grid_interpolator_test
// Self-checking bench: grid writes and point queries are streamed in under
// several origin/step settings and idle patterns. An in-bench predictor keeps
// its own grid copy and checks every interpolated value and range flag.
// ---------------------------------------------------------------------------
module bilinear_grid_interpolator_test;

	localparam int COLS = 128;
	localparam int ROWS = 128;
	localparam int SETTLE_CYCLES = 70;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		bgi_pkg::opcode_t op;
		bit [6:0]    col;
		bit [6:0]    row;
		bit [23:0]   sample;
		bit [31:0]   qx;
		bit [31:0]   qy;
	} grid_item_t;

	typedef struct {
		bit [23:0] value;
		bit        oor;
	} interp_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;   // grid_col, grid_row, sample_value, query_x, query_y
	logic [0:0]   s_tuser;   // opcode
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;   // interpolated_value
	logic [0:0]   m_tuser;   // out_of_range
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;

	bilinear_grid_interpolator i_dut (.*);

	grid_item_t pending_items[$];
	interp_t    expected_interp[$];
	grid_item_t cur_item;

	// predictor state
	bit [23:0] grid_copy[COLS*ROWS];
	bit        seeded[COLS*ROWS];
	longint    x_org, y_org, x_stp, y_stp;

	int  idle_mode;
	bit  hold_request;
	int  hold_count;
	bit  in_accepted;
	int  error_count;
	int  stall_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// floor index and 16-bit fraction of one axis; returns 1 when clamped
	function automatic bit locate_axis(input longint coord, input longint org,
			input longint stp, input longint count, output longint idx, output longint frac);
		longint d, q, r, w;
		d = coord - org;
		q = d / stp;
		r = d % stp;
		if (r < 0) begin
			q -= 1;
			r += stp;
		end
		w = (r << 16) / stp;
		if (q < 0) begin
			idx = 0; frac = 0;
			return 1'b1;
		end
		if (q > count - 1 || (q == count - 1 && w != 0)) begin
			idx = count - 1; frac = 0;
			return 1'b1;
		end
		idx = q; frac = w;
		return 1'b0;
	endfunction

	function automatic void neighbor_cells(input bit [31:0] qx, input bit [31:0] qy,
			output longint fi, output longint ci, output longint fj, output longint cj,
			output longint wx, output longint wy, output bit oor);
		bit ox, oy;
		ox = locate_axis(longint'($signed(qx)), x_org, x_stp, COLS, fi, wx);
		oy = locate_axis(longint'($signed(qy)), y_org, y_stp, ROWS, fj, wy);
		oor = ox | oy;
		ci = (fi + 1 < COLS) ? fi + 1 : fi;
		cj = (fj + 1 < ROWS) ? fj + 1 : fj;
	endfunction

	function automatic longint cell_value(input longint col, input longint row);
		return longint'($signed(grid_copy[row*COLS + col]));
	endfunction

	function automatic void interpolate_point(input grid_item_t it);
		longint fi, ci, fj, cj, wx, wy, acc, res;
		bit oor;
		interp_t e;
		neighbor_cells(it.qx, it.qy, fi, ci, fj, cj, wx, wy, oor);
		acc = (65536 - wx) * (65536 - wy) * cell_value(fi, fj)
			+ wx * (65536 - wy) * cell_value(ci, fj)
			+ wx * wy * cell_value(ci, cj)
			+ (65536 - wx) * wy * cell_value(fi, cj);
		res = (acc + (64'sd1 <<< 31)) >>> 32;
		if (res > 8388607) res = 8388607;
		if (res < -8388608) res = -8388608;
		e.value = res[23:0];
		e.oor = oor;
		expected_interp = {expected_interp, e};
	endfunction

	task automatic push_write(input int col, input int row, input bit [23:0] v);
		grid_item_t it;
		it = '{bgi_pkg::OP_WRITE, 7'(col), 7'(row), v, $urandom, $urandom};
		seeded[row*COLS + col] = 1'b1;
		pending_items = {pending_items, it};
	endtask

	// seed any unwritten neighbor first so no query reads an empty entry
	task automatic push_query(input bit [31:0] qx, input bit [31:0] qy);
		longint fi, ci, fj, cj, wx, wy;
		bit oor;
		grid_item_t it;
		neighbor_cells(qx, qy, fi, ci, fj, cj, wx, wy, oor);
		if (!seeded[fj*COLS + fi]) push_write(int'(fi), int'(fj), 24'($urandom));
		if (!seeded[fj*COLS + ci]) push_write(int'(ci), int'(fj), 24'($urandom));
		if (!seeded[cj*COLS + fi]) push_write(int'(fi), int'(cj), 24'($urandom));
		if (!seeded[cj*COLS + ci]) push_write(int'(ci), int'(cj), 24'($urandom));
		it = '{bgi_pkg::OP_QUERY, 7'($urandom), 7'($urandom), 24'($urandom), qx, qy};
		pending_items = {pending_items, it};
	endtask

	function automatic bit [31:0] grid_coord(input longint org, input longint stp,
			input int count);
		longint c;
		c = org + longint'($urandom_range(0, count - 1)) * stp
			+ longint'($urandom_range(0, 32'(stp - 1)));
		return c[31:0];
	endfunction

	task automatic write_register(input bgi_pkg::cfg_index_t idx, input bit [31:0] v);
		longint s;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			bgi_pkg::CFG_X_ORIGIN: x_org = longint'($signed(v));
			bgi_pkg::CFG_X_STEP: begin
				s = v[30:0];
				x_stp = (s == 0) ? 1 : s;
			end
			bgi_pkg::CFG_Y_ORIGIN: y_org = longint'($signed(v));
			bgi_pkg::CFG_Y_STEP: begin
				s = v[30:0];
				y_stp = (s == 0) ? 1 : s;
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || s_tvalid || expected_interp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// fills the queue to about n items, seeding writes included
	task automatic random_items(input int n);
		int k;
		while (pending_items.size() < n) begin
			k = $urandom_range(0, 99);
			if (k < 40)
				push_write($urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
					24'($urandom));
			else if (k < 88)
				push_query(grid_coord(x_org, x_stp, COLS), grid_coord(y_org, y_stp, ROWS));
			else
				push_query($urandom, $urandom);
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			if (cur_item.op == bgi_pkg::OP_WRITE)
				grid_copy[int'(cur_item.row)*COLS + int'(cur_item.col)] = cur_item.sample;
			else
				interpolate_point(cur_item);
			in_accepted = 1'b1;
		end
	end

	always @(negedge clk) begin
		bit gap;
		if (arst_n && (!s_tvalid || in_accepted)) begin
			in_accepted = 1'b0;
			gap = (idle_mode == 1 && $urandom_range(0, 99) < 54)
				|| (idle_mode == 3 && $urandom_range(0, 99) < 24);
			if (!gap && pending_items.size() != 0) begin
				cur_item = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= cur_item.op;
				s_tdata <= {2'b00, cur_item.qy, cur_item.qx, cur_item.sample,
					cur_item.row, cur_item.col};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver with a long hold-off on request
	always @(negedge clk) begin
		if (hold_request && hold_count == 0) hold_count = 400;
		if (hold_count > 0) begin
			hold_count--;
			if (hold_count == 0) hold_request = 1'b0;
			m_tready <= 1'b0;
		end else if (idle_mode == 2)
			m_tready <= $urandom_range(0, 99) >= 54;
		else if (idle_mode == 3)
			m_tready <= $urandom_range(0, 99) >= 24;
		else
			m_tready <= 1'b1;
	end

	// monitor
	always @(posedge clk) begin
		interp_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_interp.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 0);
			end else begin
				e = expected_interp.pop_front();
				if (m_tdata !== e.value) report_mismatch("interpolated_value", m_tdata, e.value);
				if (m_tuser[0] !== e.oor) report_mismatch("out_of_range", m_tuser, e.oor);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = bgi_pkg::CFG_X_ORIGIN;
		cfg_data = '0;
		idle_mode = 0;
		hold_request = 1'b0;
		hold_count = 0;
		in_accepted = 1'b0;
		error_count = 0;
		stall_cycles = 0;
		x_org = 0; y_org = 0; x_stp = 256; y_stp = 256;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, reset settings
		push_write(0, 0, 24'h7FFFFF);
		push_write(1, 0, 24'h800000);
		push_write(0, 1, 24'h000001);
		push_write(1, 1, 24'hFFFFFF);
		push_write(127, 127, 24'h7FFFFF);
		push_query(32'd128, 32'd128);                     // cell center, mixed extremes
		push_query(32'd0, 32'd0);
		push_query(32'h8000_0000, 32'h8000_0000);         // below the grid
		push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);         // past the grid
		push_query(32'd127 * 256, 32'd127 * 256);         // last index, zero fraction
		push_query(32'd127 * 256 + 1, 32'd64);            // last index, nonzero fraction
		push_query(32'hFFFF_FFFF, 32'd255);               // just below origin
		push_query(32'd255, 32'd1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_register(bgi_pkg::CFG_X_ORIGIN, 32'd0);
					write_register(bgi_pkg::CFG_X_STEP, 32'd256);
					write_register(bgi_pkg::CFG_Y_ORIGIN, 32'd0);
					write_register(bgi_pkg::CFG_Y_STEP, 32'd256);
				end
				1: begin
					write_register(bgi_pkg::CFG_X_ORIGIN, 32'h8000_0000);
					write_register(bgi_pkg::CFG_X_STEP, 32'h7FFF_FFFF);
					write_register(bgi_pkg::CFG_Y_ORIGIN, 32'h7FFF_FFFF);
					write_register(bgi_pkg::CFG_Y_STEP, 32'd1);
				end
				2: begin
					write_register(bgi_pkg::CFG_X_ORIGIN, -32'sd5000);
					write_register(bgi_pkg::CFG_X_STEP, 32'h8000_0000);   // zero step, top bit set
					write_register(bgi_pkg::CFG_Y_ORIGIN, 32'd777);
					write_register(bgi_pkg::CFG_Y_STEP, 32'd0);
				end
				default: begin
					write_register(bgi_pkg::CFG_X_ORIGIN, $urandom);
					write_register(bgi_pkg::CFG_X_STEP,
						$urandom_range(1, 5000) | (32'($urandom) << 31));
					write_register(bgi_pkg::CFG_Y_ORIGIN, $urandom);
					write_register(bgi_pkg::CFG_Y_STEP, $urandom_range(1, 1 << 20));
				end
			endcase
			idle_mode = ph % 4;
			if (ph == 4) begin
				idle_mode = 0;
				hold_request = 1'b1;
			end
			random_items(180);
			drain();
		end

		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
